@@ rtl/dtsg_pkg.sv @@
// Shared types, constants and the sine table generator for the DDS tone core.
// No dependencies; used by dtsg_sine_rom and dds_tone_sample_generator_core.
package dtsg_pkg;

    localparam int          SINE_TABLE_SIZE = 512;
    localparam int          STEP_W          = 20;
    localparam logic [19:0] STEP_RESET      = 20'd134217;
    localparam int          PHASE_W         = 31;
    localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
    localparam logic [15:0] PIX_F_LOW       = 16'd1500;
    localparam logic [7:0]  BIAS_BIT        = 8'h80;
    localparam int          OUT_SHIFT       = 24 - 1;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 21;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef enum logic [1:0] {
        OP_TONE  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_STEP,
        S_ACC,
        S_MUL_IDX,
        S_RD_A,
        S_RD_B,
        S_MUL_B,
        S_MUL_AMP,
        S_OUT
    } t_state;

    // q15 sine point from a folded first-quadrant angle x in Q30 (Taylor series)
    function automatic logic signed [15:0] sine_from_x(input logic [63:0] x,
                                                       input logic neg);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
        r = (sum + 64'd16384) >> 15;
        if (neg) begin
            return 16'(64'd0 - r);
        end else if (r > 64'd32767) begin
            return 16'h7fff;
        end
        return 16'(r);
    endfunction

endpackage

@@ rtl/dtsg_sine_rom.sv @@
// Sine lookup table with SINE_TABLE_SIZE+1 q15 points and a registered read port.
// Depends on dtsg_pkg for the table generator function.
module dtsg_sine_rom #(
    parameter int SINE_TABLE_SIZE = dtsg_pkg::SINE_TABLE_SIZE,
    parameter int AW              = $clog2(SINE_TABLE_SIZE + 1)
) (
    input  logic                 i_clk,
    input  logic [AW-1:0]        i_addr,
    output logic signed [15:0]   o_data
);

    logic signed [15:0] w_tab [0:SINE_TABLE_SIZE];
    logic signed [15:0] r_data;

    for (genvar k = 0; k <= SINE_TABLE_SIZE; k++) begin : g_pt
        localparam int KK = k % SINE_TABLE_SIZE;
        localparam int M  = 4 * KK;
        localparam int N  = SINE_TABLE_SIZE;
        localparam int A  = (M <= N) ? M :
                            (M <= 2 * N) ? 2 * N - M :
                            (M <= 3 * N) ? M - 2 * N : 4 * N - M;
        localparam logic NEG = (M > 2 * N);
        localparam logic [63:0] X = (dtsg_pkg::HALF_PI_Q30 * 64'(A)) / 64'(SINE_TABLE_SIZE);
        assign w_tab[k] = dtsg_pkg::sine_from_x(X, NEG);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;

endmodule

@@ rtl/dds_tone_sample_generator_core.sv @@
// DDS tone core: phase accumulator, interpolated sine lookup and amplitude scaling.
// A tone or pixel transfer runs through MUL_STEP, ACC, MUL_IDX, RD_A, RD_B, MUL_B, MUL_AMP
// and OUT before its sample loads m_axis; no new item is taken until then, set by the single
// shared multiplier and the one read port of the sine table; hold in OUT while the prior
// sample waits. Clear and unused requests give no output. Reset (i_rst_n low, synchronous)
// clears phase, sequencer and output valid, and loads the 16 kHz step default.
module dds_tone_sample_generator_core #(
    parameter int SINE_TABLE_SIZE = dtsg_pkg::SINE_TABLE_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: phase_step_per_hz
    input  logic        i_cfg_wvalid,
    output logic        o_cfg_wready,
    input  logic [19:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // tone_freq_hz[15:0], pixel_value[23:16], amplitude[39:24]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // sample[7:0]
);

    localparam int AW = $clog2(SINE_TABLE_SIZE + 1);
    localparam int IW = $clog2(SINE_TABLE_SIZE);
    localparam int AN = dtsg_pkg::MUL_A_W;
    localparam int BN = dtsg_pkg::MUL_B_W;
    localparam int PN = dtsg_pkg::PROD_W;

    dtsg_pkg::t_state r_state, n_state;

    logic [dtsg_pkg::STEP_W-1:0]  r_step;
    logic [dtsg_pkg::PHASE_W-1:0] r_phase;
    logic [15:0]                  r_freq;
    logic signed [15:0]           r_amp;
    logic signed [PN-1:0]         r_prod;
    logic [14:0]                  r_frac;
    logic [AW-1:0]                r_idx;
    logic [15:0]                  r_t;
    logic [7:0]                   r_out_data;
    logic                         r_out_valid;

    dtsg_pkg::t_op      w_op;
    logic               w_accept;
    logic [7:0]         w_pix;
    logic [13:0]        w_pix35;
    logic [13:0]        w_pix_q;
    logic [15:0]        w_pix_freq;
    logic [AW-1:0]      w_rom_addr;
    logic signed [15:0] w_rom_q;
    logic signed [AN-1:0] w_mul_a;
    logic signed [BN-1:0] w_mul_b;
    logic signed [PN-1:0] w_prod;
    logic [15:0]        w_u;
    logic [15:0]        w_s;
    logic               w_out_load;

    assign o_cfg_wready = 1'b1;
    assign w_op         = dtsg_pkg::t_op'(s_axis_tuser);
    assign w_accept     = s_axis_tvalid && s_axis_tready;

    // pixel frequency: 1500 + 800*v/255 = 1500 + 3v + (35v)/255, exact below 65280
    assign w_pix      = s_axis_tdata[23:16];
    assign w_pix35    = {1'b0, w_pix, 5'b0} + {5'b0, w_pix, 1'b0} + {6'b0, w_pix};
    assign w_pix_q    = (w_pix35 + 14'd1 + {8'b0, w_pix35[13:8]}) >> 8;
    assign w_pix_freq = dtsg_pkg::PIX_F_LOW + {6'b0, w_pix, 2'b0} - {8'b0, w_pix}
                        + {2'b0, w_pix_q};

    dtsg_sine_rom #(
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE),
        .AW              (AW)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_q)
    );

    assign w_prod = w_mul_a * w_mul_b;
    assign w_u    = r_t + 16'(r_prod[31:16]);
    assign w_s    = {w_u[14:0], 1'b0};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dtsg_pkg::S_IDLE: begin
                if (w_accept && (w_op == dtsg_pkg::OP_TONE || w_op == dtsg_pkg::OP_PIXEL)) begin
                    n_state = dtsg_pkg::S_MUL_STEP;
                end
            end
            dtsg_pkg::S_MUL_STEP: n_state = dtsg_pkg::S_ACC;
            dtsg_pkg::S_ACC:      n_state = dtsg_pkg::S_MUL_IDX;
            dtsg_pkg::S_MUL_IDX:  n_state = dtsg_pkg::S_RD_A;
            dtsg_pkg::S_RD_A:     n_state = dtsg_pkg::S_RD_B;
            dtsg_pkg::S_RD_B:     n_state = dtsg_pkg::S_MUL_B;
            dtsg_pkg::S_MUL_B:    n_state = dtsg_pkg::S_MUL_AMP;
            dtsg_pkg::S_MUL_AMP:  n_state = dtsg_pkg::S_OUT;
            dtsg_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = dtsg_pkg::S_IDLE;
                end
            end
            default: n_state = dtsg_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands, table address, handshakes
    always_comb begin
        s_axis_tready = 1'b0;
        w_out_load    = 1'b0;
        w_mul_a       = '0;
        w_mul_b       = '0;
        w_rom_addr    = r_idx + AW'(1);
        unique case (r_state)
            dtsg_pkg::S_IDLE: s_axis_tready = 1'b1;
            dtsg_pkg::S_MUL_STEP: begin
                w_mul_a = AN'(r_step);
                w_mul_b = BN'(r_freq);
            end
            dtsg_pkg::S_MUL_IDX: begin
                w_mul_a = AN'(r_phase[30:16]);
                w_mul_b = BN'(SINE_TABLE_SIZE);
            end
            dtsg_pkg::S_RD_A: w_rom_addr = AW'(r_prod[15 +: IW]);
            dtsg_pkg::S_RD_B: begin
                // weight of the lower point
                w_mul_a = AN'(17'd32768 - {2'b0, r_frac});
                w_mul_b = BN'(w_rom_q);
            end
            dtsg_pkg::S_MUL_B: begin
                w_mul_a = AN'(r_frac);
                w_mul_b = BN'(w_rom_q);
            end
            dtsg_pkg::S_MUL_AMP: begin
                w_mul_a = AN'($signed(w_s));
                w_mul_b = BN'(r_amp);
            end
            dtsg_pkg::S_OUT: w_out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtsg_pkg::S_IDLE;
            r_step      <= dtsg_pkg::STEP_RESET;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wvalid && o_cfg_wready) begin
                r_step <= i_cfg_wdata;
            end
            if (w_accept && w_op == dtsg_pkg::OP_CLEAR) begin
                r_phase <= '0;
            end else if (r_state == dtsg_pkg::S_ACC) begin
                r_phase <= r_phase + r_prod[30:0];
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        // hold the scaled sample while it waits for the output register
        if (r_state != dtsg_pkg::S_OUT) begin
            r_prod <= w_prod;
        end
        if (w_accept) begin
            r_freq <= (w_op == dtsg_pkg::OP_PIXEL) ? w_pix_freq : s_axis_tdata[15:0];
            r_amp  <= $signed(s_axis_tdata[39:24]);
        end
        if (r_state == dtsg_pkg::S_RD_A) begin
            r_idx  <= AW'(r_prod[15 +: IW]);
            r_frac <= r_prod[14:0];
        end
        if (r_state == dtsg_pkg::S_MUL_B) begin
            r_t <= r_prod[31:16];
        end
        if (w_out_load) begin
            r_out_data <= r_prod[dtsg_pkg::OUT_SHIFT +: 8] ^ dtsg_pkg::BIAS_BIT;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == dtsg_pkg::S_IDLE)
        else $error("input ready outside idle");

    a_clear_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == dtsg_pkg::OP_CLEAR) |=> r_phase == '0)
        else $error("clear request did not zero the phase");

    a_unused_op_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == dtsg_pkg::OP_NONE) |=> $stable(r_phase) && r_state == dtsg_pkg::S_IDLE)
        else $error("unused op changed state");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dtsg_pkg::S_RD_A |-> r_prod[15 +: IW] <= IW'(SINE_TABLE_SIZE - 1))
        else $error("sine index beyond table");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> r_out_valid && $stable(r_out_data))
        else $error("pending sample overwritten");

endmodule
